// File: hdl/qsc_pkg.sv
// Shared constants, widths, codes and the CORDIC angle table for the square checker.
// Used by every module in this folder; depends on nothing else.
`default_nettype none

package qsc_pkg;

    // Input geometry
    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;       // signed edge component
    localparam int PROD_W     = 2 * COORD_BITS + 1;   // signed product of two components
    localparam int SUM_W      = 2 * COORD_BITS + 2;   // signed dot or cross product
    localparam int SQ_W       = 2 * COORD_BITS + 1;   // unsigned squared side length

    // Square root chain (side length in Q.4)
    localparam int ROOT_W = COORD_BITS + 5;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Angle unit
    localparam int NORM_W       = 40;
    localparam int NORM_STEPS   = 6;
    localparam int CORD_W       = NORM_W + 4;
    localparam int Z_W          = 22;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 5;
    localparam int ANG_W        = 16;
    localparam logic signed [Z_W-1:0] HALF_PI_FINE = 22'sd524288;
    localparam logic [ANG_W-1:0]      ANG_MAX      = 16'd32768;

    // Pipeline depths
    localparam int ANG_LAT   = 2 + NORM_STEPS + CORDIC_STEPS + 1;
    localparam int ROOT_PAD  = ANG_LAT - ROOT_W;
    localparam int FRONT_LAT = 4;
    localparam int BACK_LAT  = 3;
    localparam int PIPE_LAT  = FRONT_LAT + ANG_LAT + BACK_LAT;

    // Configuration
    localparam int TOL_W    = 16;
    localparam int ORIENT_W = 17;
    localparam int COEF_W   = TOL_W + 1;
    localparam int CFG_AW   = 4;
    localparam logic [1:0] REG_LENGTH_TOL = 2'd0;
    localparam logic [1:0] REG_ANGLE_TOL  = 2'd1;
    localparam logic [1:0] REG_MIN_ORIENT = 2'd2;
    localparam logic [1:0] REG_MAX_ORIENT = 2'd3;

    // Result
    localparam int MSIDE_W = 17;
    localparam logic [2:0] FS_PASS   = 3'd0;
    localparam logic [2:0] FS_SIDE   = 3'd1;
    localparam logic [2:0] FS_TURN   = 3'd2;
    localparam logic [2:0] FS_ORIENT = 3'd3;
    localparam logic [2:0] FS_DEGEN  = 3'd4;

    typedef struct packed {
        logic [ANG_W-1:0]   mean_turn;
        logic [MSIDE_W-1:0] mean_side;
        logic [2:0]         fail_stage;
        logic               is_square;
    } t_result;

    localparam int RES_W = $bits(t_result);
    localparam int IN_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    // atan(2^-i) in units of pi/2^20, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 22'sd262144;
            5'd1:    v = 22'sd154753;
            5'd2:    v = 22'sd81767;
            5'd3:    v = 22'sd41506;
            5'd4:    v = 22'sd20834;
            5'd5:    v = 22'sd10427;
            5'd6:    v = 22'sd5215;
            5'd7:    v = 22'sd2608;
            5'd8:    v = 22'sd1304;
            5'd9:    v = 22'sd652;
            5'd10:   v = 22'sd326;
            5'd11:   v = 22'sd163;
            5'd12:   v = 22'sd81;
            5'd13:   v = 22'sd41;
            5'd14:   v = 22'sd20;
            5'd15:   v = 22'sd10;
            5'd16:   v = 22'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/qsc_root_cell.sv
// One restoring square-root cell: takes two radicand bits and yields one root bit.
// Depends on qsc_pkg for widths.
`default_nettype none

module qsc_root_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [qsc_pkg::RAD_W-1:0]    i_rad,
    input  logic [qsc_pkg::REM_W-1:0]    i_rem,
    input  logic [qsc_pkg::ROOT_W-1:0]   i_root,
    output logic [qsc_pkg::RAD_W-1:0]    o_rad,
    output logic [qsc_pkg::REM_W-1:0]    o_rem,
    output logic [qsc_pkg::ROOT_W-1:0]   o_root
);

    logic [qsc_pkg::RAD_W-1:0]  r_rad, n_rad;
    logic [qsc_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [qsc_pkg::ROOT_W-1:0] r_root, n_root;
    logic [qsc_pkg::REM_W-1:0]  w_cur;
    logic [qsc_pkg::REM_W-1:0]  w_trial;

    always_comb begin
        w_cur   = {i_rem[qsc_pkg::REM_W-3:0], i_rad[qsc_pkg::RAD_W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        n_rad   = {i_rad[qsc_pkg::RAD_W-3:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_rem  = w_cur - w_trial;
            n_root = {i_root[qsc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_cur;
            n_root = {i_root[qsc_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hdl/qsc_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle accumulator step.
// Depends on qsc_pkg for widths and the arctangent table.
`default_nettype none

module qsc_cordic_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [qsc_pkg::STEP_W-1:0]          i_step,
    input  logic signed [qsc_pkg::CORD_W-1:0]   i_x,
    input  logic signed [qsc_pkg::CORD_W-1:0]   i_y,
    input  logic signed [qsc_pkg::Z_W-1:0]      i_z,
    output logic signed [qsc_pkg::CORD_W-1:0]   o_x,
    output logic signed [qsc_pkg::CORD_W-1:0]   o_y,
    output logic signed [qsc_pkg::Z_W-1:0]      o_z
);

    logic signed [qsc_pkg::CORD_W-1:0] w_xs, w_ys, n_x, n_y, r_x, r_y;
    logic signed [qsc_pkg::Z_W-1:0]    w_atan, n_z, r_z;

    always_comb begin
        // Arithmetic shifts round toward minus infinity.
        w_xs   = i_x >>> i_step;
        w_ys   = i_y >>> i_step;
        w_atan = qsc_pkg::atan_step(i_step);
        if (i_y >= 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_atan;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

// File: hdl/qsc_angle_lane.sv
// Angle unit: atan2(|y|, x) in units of pi/32768 through absolute value, quadrant
// pre-rotation, staged normalization and a row of CORDIC cells. Uses qsc_pkg, qsc_cordic_cell.
`default_nettype none

module qsc_angle_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qsc_pkg::SUM_W-1:0]   i_x,
    input  logic signed [qsc_pkg::SUM_W-1:0]   i_y,
    output logic [qsc_pkg::ANG_W-1:0]          o_angle
);

    logic signed [qsc_pkg::SUM_W-1:0] r_ax;
    logic [qsc_pkg::SUM_W-1:0]        r_ay;
    logic [qsc_pkg::SUM_W-1:0]        w_negx;

    logic [qsc_pkg::NORM_W-1:0]     r_nx [0:qsc_pkg::NORM_STEPS];
    logic [qsc_pkg::NORM_W-1:0]     r_ny [0:qsc_pkg::NORM_STEPS];
    logic signed [qsc_pkg::Z_W-1:0] r_nz [0:qsc_pkg::NORM_STEPS];

    logic signed [qsc_pkg::CORD_W-1:0] w_cx [0:qsc_pkg::CORDIC_STEPS];
    logic signed [qsc_pkg::CORD_W-1:0] w_cy [0:qsc_pkg::CORDIC_STEPS];
    logic signed [qsc_pkg::Z_W-1:0]    w_cz [0:qsc_pkg::CORDIC_STEPS];

    logic signed [qsc_pkg::Z_W-1:0] w_zpos;
    logic [qsc_pkg::Z_W-1:0]        w_round;
    logic [qsc_pkg::ANG_W-1:0]      r_angle, n_angle;

    assign w_negx = qsc_pkg::SUM_W'(-r_ax);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= i_x;
            r_ay <= (i_y < 0) ? qsc_pkg::SUM_W'(-i_y) : qsc_pkg::SUM_W'(i_y);
            // A vector with negative x is turned by pi/2 into the right half plane.
            if (r_ax < 0) begin
                r_nx[0] <= qsc_pkg::NORM_W'(r_ay);
                r_ny[0] <= qsc_pkg::NORM_W'(w_negx);
                r_nz[0] <= qsc_pkg::HALF_PI_FINE;
            end else begin
                r_nx[0] <= qsc_pkg::NORM_W'(qsc_pkg::SUM_W'(r_ax));
                r_ny[0] <= qsc_pkg::NORM_W'(r_ay);
                r_nz[0] <= '0;
            end
        end
    end

    // Leading-zero normalization, one binary shift size per stage.
    for (genvar k = 0; k < qsc_pkg::NORM_STEPS; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic w_small;
        assign w_small = (((r_nx[k] | r_ny[k]) >> (qsc_pkg::NORM_W - SH)) == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[k+1] <= w_small ? (r_nx[k] << SH) : r_nx[k];
                r_ny[k+1] <= w_small ? (r_ny[k] << SH) : r_ny[k];
                r_nz[k+1] <= r_nz[k];
            end
        end
    end

    assign w_cx[0] = signed'(qsc_pkg::CORD_W'(r_nx[qsc_pkg::NORM_STEPS]));
    assign w_cy[0] = signed'(qsc_pkg::CORD_W'(r_ny[qsc_pkg::NORM_STEPS]));
    assign w_cz[0] = r_nz[qsc_pkg::NORM_STEPS];

    for (genvar k = 0; k < qsc_pkg::CORDIC_STEPS; k++) begin : g_cordic
        qsc_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (qsc_pkg::STEP_W'(k)),
            .i_x    (w_cx[k]),
            .i_y    (w_cy[k]),
            .i_z    (w_cz[k]),
            .o_x    (w_cx[k+1]),
            .o_y    (w_cy[k+1]),
            .o_z    (w_cz[k+1])
        );
    end

    always_comb begin
        w_zpos  = (w_cz[qsc_pkg::CORDIC_STEPS] < 0) ? '0 : w_cz[qsc_pkg::CORDIC_STEPS];
        w_round = (qsc_pkg::Z_W'(w_zpos) + qsc_pkg::Z_W'(16)) >> 5;
        if (w_round > qsc_pkg::Z_W'(qsc_pkg::ANG_MAX)) begin
            n_angle = qsc_pkg::ANG_MAX;
        end else begin
            n_angle = w_round[qsc_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// File: hdl/quad_square_check.sv
// Top level of the quadrilateral square checker: stream ports, configuration
// registers, edge arithmetic, side-length and angle chains, and the verdict.
// Uses qsc_pkg, qsc_root_cell and qsc_angle_lane.
//
//  Channel      Direction  Handshake                 Content
//  s_axis       in         tvalid / tready           four corners x0..y3
//  m_axis       out        tvalid / tready           verdict, stage, means
//  APB          in/out     psel, penable, pwrite     tolerances and window
//
// One transaction per cycle is taken while the skid register is empty; each result passes the front
// stages, the 26-stage angle unit (6 normalization and 17 CORDIC cells) and the back stages.
// Reset is synchronous, clears the valid chain, the output slot and the skid slot, and loads the registers' defaults.
// A stalled output holds one result in the output register and one in a skid
// register; input ready drops only once the skid register is occupied.
`default_nettype none

module quad_square_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // x0, y0, x1, y1, x2, y2, x3, y3 from the lowest bit up
    input  logic [qsc_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // is_square, fail_stage, mean_side, mean_turn from the lowest bit up, zero padded
    output logic [qsc_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qsc_pkg::CFG_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int C      = qsc_pkg::COORD_BITS;
    localparam int LSUM_W = qsc_pkg::ROOT_W + 2;
    localparam int ASUM_W = qsc_pkg::ANG_W + 2;
    localparam int LP_W   = LSUM_W + qsc_pkg::COEF_W;
    localparam int AP_W   = ASUM_W + qsc_pkg::COEF_W;
    localparam int HW     = qsc_pkg::ORIENT_W + 1;

    // ---------------- configuration ----------------
    logic [qsc_pkg::TOL_W-1:0]           r_length_tol, r_angle_tol;
    logic signed [qsc_pkg::ORIENT_W-1:0] r_min_orient, r_max_orient;
    logic [1:0]                          w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[qsc_pkg::CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_tol <= 16'd6554;
            r_angle_tol  <= 16'd6554;
            r_min_orient <= -17'sd4096;
            r_max_orient <= 17'sd4096;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                qsc_pkg::REG_LENGTH_TOL: r_length_tol <= pwdata[qsc_pkg::TOL_W-1:0];
                qsc_pkg::REG_ANGLE_TOL:  r_angle_tol  <= pwdata[qsc_pkg::TOL_W-1:0];
                qsc_pkg::REG_MIN_ORIENT: r_min_orient <= signed'(pwdata[qsc_pkg::ORIENT_W-1:0]);
                qsc_pkg::REG_MAX_ORIENT: r_max_orient <= signed'(pwdata[qsc_pkg::ORIENT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            qsc_pkg::REG_LENGTH_TOL: prdata = 32'(r_length_tol);
            qsc_pkg::REG_ANGLE_TOL:  prdata = 32'(r_angle_tol);
            qsc_pkg::REG_MIN_ORIENT: prdata = 32'(r_min_orient);
            qsc_pkg::REG_MAX_ORIENT: prdata = 32'(r_max_orient);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic                    w_en;
    logic [qsc_pkg::PIPE_LAT-1:0] r_vld;
    logic                    r_out_v, r_skid_v;
    qsc_pkg::t_result        r_res, n_res, r_out, r_skid;

    assign w_en            = ~r_skid_v;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[qsc_pkg::PIPE_LAT-2:0], i_s_axis_tvalid};
        end
    end

    // ---------------- front: corners, edges, products ----------------
    logic [C-1:0]                        r_px [0:3];
    logic [C-1:0]                        r_py [0:3];
    logic signed [qsc_pkg::DIFF_W-1:0]   r_ex [0:3];
    logic signed [qsc_pkg::DIFF_W-1:0]   r_ey [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_sqx [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_sqy [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_dxx [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_dyy [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_cxy [0:3];
    logic signed [qsc_pkg::PROD_W-1:0]   r_cyx [0:3];
    logic signed [qsc_pkg::DIFF_W-1:0]   r_ex0_p, r_ey0_p;
    logic [qsc_pkg::SQ_W-1:0]            r_sq [0:3];
    logic signed [qsc_pkg::SUM_W-1:0]    r_dot [0:3];
    logic signed [qsc_pkg::SUM_W-1:0]    r_crs [0:3];
    logic signed [qsc_pkg::SUM_W-1:0]    r_ox, r_oy;
    logic signed [qsc_pkg::SUM_W-1:0]    w_sqsum [0:3];

    for (genvar i = 0; i < 4; i++) begin : g_front
        localparam int J = (i + 1) % 4;
        assign w_sqsum[i] = qsc_pkg::SUM_W'(r_sqx[i]) + qsc_pkg::SUM_W'(r_sqy[i]);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_px[i]  <= i_s_axis_tdata[2*i*C +: C];
                r_py[i]  <= i_s_axis_tdata[(2*i+1)*C +: C];
                r_ex[i]  <= signed'({1'b0, r_px[J]}) - signed'({1'b0, r_px[i]});
                r_ey[i]  <= signed'({1'b0, r_py[J]}) - signed'({1'b0, r_py[i]});
                r_sqx[i] <= qsc_pkg::PROD_W'(r_ex[i]) * qsc_pkg::PROD_W'(r_ex[i]);
                r_sqy[i] <= qsc_pkg::PROD_W'(r_ey[i]) * qsc_pkg::PROD_W'(r_ey[i]);
                r_dxx[i] <= qsc_pkg::PROD_W'(r_ex[i]) * qsc_pkg::PROD_W'(r_ex[J]);
                r_dyy[i] <= qsc_pkg::PROD_W'(r_ey[i]) * qsc_pkg::PROD_W'(r_ey[J]);
                r_cxy[i] <= qsc_pkg::PROD_W'(r_ex[i]) * qsc_pkg::PROD_W'(r_ey[J]);
                r_cyx[i] <= qsc_pkg::PROD_W'(r_ey[i]) * qsc_pkg::PROD_W'(r_ex[J]);
                r_sq[i]  <= w_sqsum[i][qsc_pkg::SQ_W-1:0];
                r_dot[i] <= qsc_pkg::SUM_W'(r_dxx[i]) + qsc_pkg::SUM_W'(r_dyy[i]);
                r_crs[i] <= qsc_pkg::SUM_W'(r_cxy[i]) - qsc_pkg::SUM_W'(r_cyx[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ex0_p <= r_ex[0];
            r_ey0_p <= r_ey[0];
            r_ox    <= qsc_pkg::SUM_W'(r_ex0_p);
            r_oy    <= qsc_pkg::SUM_W'(r_ey0_p);
        end
    end

    // ---------------- side lengths: square-root chains ----------------
    logic [qsc_pkg::ROOT_W-1:0] w_len [0:3];

    for (genvar i = 0; i < 4; i++) begin : g_side
        logic [qsc_pkg::RAD_W-1:0]  w_rad  [0:qsc_pkg::ROOT_W];
        logic [qsc_pkg::REM_W-1:0]  w_rem  [0:qsc_pkg::ROOT_W];
        logic [qsc_pkg::ROOT_W-1:0] w_root [0:qsc_pkg::ROOT_W];
        logic [qsc_pkg::ROOT_W-1:0] r_pad  [0:qsc_pkg::ROOT_PAD-1];

        // Squared length times 256 gives the root in Q.4.
        assign w_rad[0]  = {1'b0, r_sq[i], 8'h00};
        assign w_rem[0]  = '0;
        assign w_root[0] = '0;

        for (genvar k = 0; k < qsc_pkg::ROOT_W; k++) begin : g_cell
            qsc_root_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rad  (w_rad[k]),
                .i_rem  (w_rem[k]),
                .i_root (w_root[k]),
                .o_rad  (w_rad[k+1]),
                .o_rem  (w_rem[k+1]),
                .o_root (w_root[k+1])
            );
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pad[0] <= w_root[qsc_pkg::ROOT_W];
                for (int k = 1; k < qsc_pkg::ROOT_PAD; k++) begin
                    r_pad[k] <= r_pad[k-1];
                end
            end
        end

        assign w_len[i] = r_pad[qsc_pkg::ROOT_PAD-1];
    end

    // ---------------- angles: four turns and the first edge ----------------
    logic [qsc_pkg::ANG_W-1:0] w_ang [0:3];
    logic [qsc_pkg::ANG_W-1:0] w_head;

    for (genvar i = 0; i < 4; i++) begin : g_turn
        qsc_angle_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_x     (r_dot[i]),
            .i_y     (r_crs[i]),
            .o_angle (w_ang[i])
        );
    end

    qsc_angle_lane u_head (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (r_ox),
        .i_y     (r_oy),
        .o_angle (w_head)
    );

    // ---------------- back: sums, tolerance bounds, verdict ----------------
    logic [qsc_pkg::ROOT_W-1:0] r_len1 [0:3];
    logic [qsc_pkg::ROOT_W-1:0] r_len2 [0:3];
    logic [qsc_pkg::ANG_W-1:0]  r_ang1 [0:3];
    logic [qsc_pkg::ANG_W-1:0]  r_ang2 [0:3];
    logic [qsc_pkg::ANG_W-1:0]  r_h1, r_h2;
    logic                       r_degen1, r_degen2;
    logic [LSUM_W-1:0]          r_lsum1, r_lsum2;
    logic [ASUM_W-1:0]          r_asum1, r_asum2;
    logic [LP_W-1:0]            r_llo, r_lhi;
    logic [AP_W-1:0]            r_alo, r_ahi;
    logic [qsc_pkg::COEF_W-1:0] w_lc_lo, w_lc_hi, w_ac_lo, w_ac_hi;

    assign w_lc_lo = qsc_pkg::COEF_W'(65536) - qsc_pkg::COEF_W'(r_length_tol);
    assign w_lc_hi = qsc_pkg::COEF_W'(65536) + qsc_pkg::COEF_W'(r_length_tol);
    assign w_ac_lo = qsc_pkg::COEF_W'(65536) - qsc_pkg::COEF_W'(r_angle_tol);
    assign w_ac_hi = qsc_pkg::COEF_W'(65536) + qsc_pkg::COEF_W'(r_angle_tol);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsum1  <= LSUM_W'(w_len[0]) + LSUM_W'(w_len[1])
                      + LSUM_W'(w_len[2]) + LSUM_W'(w_len[3]);
            r_asum1  <= ASUM_W'(w_ang[0]) + ASUM_W'(w_ang[1])
                      + ASUM_W'(w_ang[2]) + ASUM_W'(w_ang[3]);
            r_degen1 <= (w_len[0] == '0) || (w_len[1] == '0)
                     || (w_len[2] == '0) || (w_len[3] == '0);
            r_h1     <= w_head;
            for (int i = 0; i < 4; i++) begin
                r_len1[i] <= w_len[i];
                r_ang1[i] <= w_ang[i];
                r_len2[i] <= r_len1[i];
                r_ang2[i] <= r_ang1[i];
            end
            r_llo    <= LP_W'(r_lsum1) * LP_W'(w_lc_lo);
            r_lhi    <= LP_W'(r_lsum1) * LP_W'(w_lc_hi);
            r_alo    <= AP_W'(r_asum1) * AP_W'(w_ac_lo);
            r_ahi    <= AP_W'(r_asum1) * AP_W'(w_ac_hi);
            r_lsum2  <= r_lsum1;
            r_asum2  <= r_asum1;
            r_degen2 <= r_degen1;
            r_h2     <= r_h1;
            r_res    <= n_res;
        end
    end

    logic                       w_side_ok, w_turn_ok, w_orient_ok;
    logic [LP_W-1:0]            w_lhs_l [0:3];
    logic [AP_W-1:0]            w_lhs_a [0:3];
    logic signed [HW-1:0]       w_h0, w_h1, w_h2, w_min, w_max;
    logic [qsc_pkg::ROOT_W+qsc_pkg::MSIDE_W-1:0] w_mwide;

    function automatic logic in_window(input logic signed [HW-1:0] h,
                                       input logic signed [HW-1:0] lo,
                                       input logic signed [HW-1:0] hi);
        return (h < hi) && (h > lo);
    endfunction

    always_comb begin
        w_side_ok = 1'b1;
        w_turn_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            // Each value times 4 * 65536 against the sum scaled by 65536 -/+ tolerance.
            w_lhs_l[i] = LP_W'({r_len2[i], 18'h00000});
            w_lhs_a[i] = AP_W'({r_ang2[i], 18'h00000});
            if ((w_lhs_l[i] < r_llo) || (w_lhs_l[i] > r_lhi)) begin
                w_side_ok = 1'b0;
            end
            if ((w_lhs_a[i] < r_alo) || (w_lhs_a[i] > r_ahi)) begin
                w_turn_ok = 1'b0;
            end
        end

        w_min = HW'(r_min_orient);
        w_max = HW'(r_max_orient);
        w_h0  = signed'(HW'(r_h2));
        w_h1  = w_h0 - HW'(16384);
        w_h2  = w_h0 - HW'(32768);
        w_orient_ok = in_window(w_h0, w_min, w_max) || in_window(w_h1, w_min, w_max)
                   || in_window(w_h2, w_min, w_max);

        if (r_degen2) begin
            n_res.fail_stage = qsc_pkg::FS_DEGEN;
        end else if (!w_side_ok) begin
            n_res.fail_stage = qsc_pkg::FS_SIDE;
        end else if (!w_turn_ok) begin
            n_res.fail_stage = qsc_pkg::FS_TURN;
        end else if (!w_orient_ok) begin
            n_res.fail_stage = qsc_pkg::FS_ORIENT;
        end else begin
            n_res.fail_stage = qsc_pkg::FS_PASS;
        end
        n_res.is_square = (n_res.fail_stage == qsc_pkg::FS_PASS);

        w_mwide = (qsc_pkg::ROOT_W + qsc_pkg::MSIDE_W)'(r_lsum2[LSUM_W-1:2]);
        if (w_mwide > (qsc_pkg::ROOT_W + qsc_pkg::MSIDE_W)'({qsc_pkg::MSIDE_W{1'b1}})) begin
            n_res.mean_side = {qsc_pkg::MSIDE_W{1'b1}};
        end else begin
            n_res.mean_side = w_mwide[qsc_pkg::MSIDE_W-1:0];
        end
        n_res.mean_turn = r_degen2 ? '0 : r_asum2[ASUM_W-1:2];
    end

    // ---------------- output register and skid slot ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_vld[qsc_pkg::PIPE_LAT-1];
            end
        end else if (r_vld[qsc_pkg::PIPE_LAT-1] && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : r_res;
        end
        if (r_out_v && !i_m_axis_tready && w_en) begin
            r_skid <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = qsc_pkg::OUT_W'(r_out);

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot holds a result while the output slot is empty");

    a_verdict_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.is_square == (r_out.fail_stage == qsc_pkg::FS_PASS)))
        else $error("verdict disagrees with failing stage");

    a_degen_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.fail_stage == qsc_pkg::FS_DEGEN)) |-> (r_out.mean_turn == '0))
        else $error("degenerate quadrilateral reports a mean turn angle");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");
`endif

endmodule

`default_nettype wire
